### rtl/jse_pkg.sv
// Shared types and constants for the JSON string escaper.
package jse_pkg;

	localparam int MAX_BURST = 15;
	localparam int TAIL_BYTES = 6;
	localparam int CNT_W = 4;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] REP_B0 = 8'hEF;
	localparam logic [7:0] REP_B1 = 8'hBF;
	localparam logic [7:0] REP_B2 = 8'hBD;
	localparam logic [7:0] LEAD_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD_MAX = 8'hF4;
	localparam logic [7:0] CONT_LO = 8'h80;
	localparam logic [7:0] CONT_HI = 8'hBF;
	localparam logic [7:0] E0_LO = 8'hA0;
	localparam logic [7:0] ED_HI = 8'h9F;
	localparam logic [7:0] F0_LO = 8'h90;
	localparam logic [7:0] F4_HI = 8'h8F;

	// one input's worth of output bytes, first byte in the lowest lane
	typedef struct packed {
		logic [MAX_BURST-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      done;
	} burst_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'd0, nib};
		end else begin
			r = 8'h57 + {4'd0, nib};
		end
		return r;
	endfunction

	function automatic logic [7:0] rep_byte(input int k);
		logic [7:0] r;
		unique case (k % 3)
			0: r = REP_B0;
			1: r = REP_B1;
			default: r = REP_B2;
		endcase
		return r;
	endfunction

endpackage

### rtl/jse_decode.sv
// Escape and UTF-8 check of one input item, with the sequence state.
module jse_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               req_end,
	input  logic [7:0]         c,
	output jse_pkg::burst_t    burst
);

	logic [2:0][7:0] held_q, held_n;
	logic [1:0]      cnt_q, cnt_n;
	logic [2:0]      seq_q, seq_n;
	logic            inside_q;

	logic [7:0] lo, hi;
	logic       cont;
	logic       opening;
	logic [1:0] nrep;
	logic [jse_pkg::TAIL_BYTES-1:0][7:0] tail, fresh_tail, esc_tail, pass_tail;
	logic [2:0] tlen, fresh_len, esc_len;
	logic       fresh_lead;
	logic [2:0] fresh_seq;
	logic       done;
	logic [7:0] esc;
	logic [3:0] plen;
	logic [jse_pkg::MAX_BURST-1:0][7:0] prefix;
	logic [3:0] total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			cnt_q    <= '0;
			seq_q    <= '0;
			inside_q <= 1'b0;
		end else if (advance) begin
			held_q   <= held_n;
			cnt_q    <= cnt_n;
			seq_q    <= seq_n;
			inside_q <= !req_end;
		end
	end

	// continuation range depends on the lead for the second byte only
	always_comb begin
		lo = jse_pkg::CONT_LO;
		hi = jse_pkg::CONT_HI;
		if (cnt_q == 2'd1) begin
			if (held_q[0] == 8'hE0) lo = jse_pkg::E0_LO;
			if (held_q[0] == 8'hED) hi = jse_pkg::ED_HI;
			if (held_q[0] == 8'hF0) lo = jse_pkg::F0_LO;
			if (held_q[0] == jse_pkg::LEAD_MAX) hi = jse_pkg::F4_HI;
		end
		cont = (c >= lo) && (c <= hi);
	end

	// ASCII escaping
	always_comb begin
		esc = 8'h00;
		unique case (c)
			8'h22: esc = jse_pkg::CH_QUOTE;
			8'h5C: esc = jse_pkg::CH_BSLASH;
			8'h08: esc = 8'h62;
			8'h0C: esc = 8'h66;
			8'h0A: esc = 8'h6E;
			8'h0D: esc = 8'h72;
			8'h09: esc = 8'h74;
			default: esc = 8'h00;
		endcase
		esc_tail = '0;
		if (esc != 8'h00) begin
			esc_tail[0] = jse_pkg::CH_BSLASH;
			esc_tail[1] = esc;
			esc_len = 3'd2;
		end else if (c < jse_pkg::CH_SPACE) begin
			esc_tail[0] = jse_pkg::CH_BSLASH;
			esc_tail[1] = jse_pkg::CH_U;
			esc_tail[2] = jse_pkg::CH_ZERO;
			esc_tail[3] = jse_pkg::CH_ZERO;
			esc_tail[4] = jse_pkg::hex_char(c[7:4]);
			esc_tail[5] = jse_pkg::hex_char(c[3:0]);
			esc_len = 3'd6;
		end else begin
			esc_tail[0] = c;
			esc_len = 3'd1;
		end
	end

	// byte with no sequence held
	always_comb begin
		fresh_tail = '0;
		fresh_len  = 3'd0;
		fresh_lead = 1'b0;
		fresh_seq  = 3'd0;
		if (!c[7]) begin
			fresh_tail = esc_tail;
			fresh_len  = esc_len;
		end else if (c >= jse_pkg::LEAD_MIN && c <= jse_pkg::LEAD_MAX) begin
			fresh_lead = 1'b1;
			if (c <= jse_pkg::LEAD2_MAX) fresh_seq = 3'd2;
			else if (c <= jse_pkg::LEAD3_MAX) fresh_seq = 3'd3;
			else fresh_seq = 3'd4;
		end else begin
			fresh_tail[0] = jse_pkg::REP_B0;
			fresh_tail[1] = jse_pkg::REP_B1;
			fresh_tail[2] = jse_pkg::REP_B2;
			fresh_len     = 3'd3;
		end
	end

	// completed sequence: held bytes then the new one
	always_comb begin
		pass_tail = '0;
		for (int k = 0; k < 3; k++) begin
			if (k < int'(cnt_q)) pass_tail[k] = held_q[k];
		end
		pass_tail[{1'b0, cnt_q}] = c;
	end

	always_comb begin
		tail    = '0;
		tlen    = 3'd0;
		nrep    = 2'd0;
		done    = 1'b0;
		held_n  = held_q;
		cnt_n   = cnt_q;
		seq_n   = seq_q;
		opening = !inside_q;
		if (req_end) begin
			nrep    = cnt_q;
			tail[0] = jse_pkg::CH_QUOTE;
			tlen    = 3'd1;
			done    = 1'b1;
			held_n  = '0;
			cnt_n   = '0;
			seq_n   = '0;
		end else begin
			if (cnt_q != 2'd0 && cont) begin
				if (({1'b0, cnt_q} + 3'd1) >= seq_q || cnt_q == 2'd3) begin
					tail   = pass_tail;
					tlen   = {1'b0, cnt_q} + 3'd1;
					held_n = '0;
					cnt_n  = '0;
					seq_n  = '0;
				end else begin
					held_n[cnt_q] = c;
					cnt_n         = cnt_q + 2'd1;
				end
			end else begin
				// failed continuation: flush held bytes, then restart
				nrep   = cnt_q;
				held_n = '0;
				cnt_n  = '0;
				seq_n  = '0;
				tail   = fresh_tail;
				tlen   = fresh_len;
				if (fresh_lead) begin
					held_n[0] = c;
					cnt_n     = 2'd1;
					seq_n     = fresh_seq;
				end
			end
		end
	end

	// opening quote and replacement characters ahead of the tail
	always_comb begin
		plen = {3'd0, opening} + {2'd0, nrep} + {1'b0, nrep, 1'b0};
		prefix = '0;
		for (int i = 0; i < jse_pkg::MAX_BURST; i++) begin
			if (i < int'(plen)) begin
				if (opening) begin
					prefix[i] = (i == 0) ? jse_pkg::CH_QUOTE : jse_pkg::rep_byte(i - 1);
				end else begin
					prefix[i] = jse_pkg::rep_byte(i);
				end
			end
		end
		// an opening quote never meets held bytes, so the sum stays within 15
		total = plen + {1'b0, tlen};
		burst.bytes = prefix | ({{(jse_pkg::MAX_BURST - jse_pkg::TAIL_BYTES)*8{1'b0}}, tail}
			<< {plen, 3'b000});
		burst.count = total;
		burst.done  = done;
	end

endmodule

### rtl/jse_serial.sv
// Burst register that hands out one output byte per cycle while m_tready is high.
module jse_serial (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  jse_pkg::burst_t burst,
	output logic            ready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast,
	output logic            m_tuser
);

	logic [jse_pkg::MAX_BURST-1:0][7:0] buf_q;
	logic [jse_pkg::CNT_W-1:0]          cnt_q;
	logic                               done_q;
	logic                               busy_q;
	logic                               last;

	assign last     = (cnt_q == 4'd1);
	assign ready    = !busy_q || (m_tready && last);
	assign m_tvalid = busy_q;
	assign m_tdata  = buf_q[0];
	assign m_tlast  = last;
	assign m_tuser  = done_q && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= burst.count;
		end else if (busy_q && m_tready) begin
			busy_q <= !last;
			cnt_q  <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q  <= burst.bytes;
			done_q <= burst.done;
		end else if (busy_q && m_tready) begin
			buf_q <= {8'h00, buf_q[jse_pkg::MAX_BURST-1:1]};
		end
	end

endmodule

### rtl/json_string_escaper_utf8_top.sv
// Top level of the JSON string escaper with UTF-8 validation.
// The first output byte of an item comes from the burst register, which is loaded
// once the item has passed the input register and the burst register is free.
// Throughput: one item per cycle while items expand to one byte and m_tready is high;
// an item that expands to n bytes (up to 15) holds the output burst register until
// all n are taken, and an item that only extends a held UTF-8 sequence gives no output.
// Reset (arst_n low) clears the sequence state, the inside-string flag and all valids.
module json_string_escaper_utf8_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       s_tuser,   // req_type (1 = end of string)
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast,   // run_last
	output logic       m_tuser    // string_done
);

	// input register
	logic       valid_s1;
	logic       req_s1;
	logic [7:0] byte_s1;

	logic            ser_ready;
	logic            advance;
	logic            load;
	jse_pkg::burst_t burst;

	// the item in the input register moves on once the burst register frees up
	assign advance  = valid_s1 && ser_ready;
	// items that only grow a held sequence produce no burst
	assign load     = advance && (burst.count != 4'd0);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// hold the payload until the item is taken in
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	jse_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req_end (req_s1),
		.c       (byte_s1),
		.burst   (burst)
	);

	jse_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst    (burst),
		.ready    (ser_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
